/* sv/bbd_pkg.sv */
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants of the ILBM ByteRun1 body decoder.
// ----------------------------------------------------------------------------
package bbd_pkg;

    // Default bounds of the picture geometry.
    localparam int MAX_ROW_BYTES_DEF = 1024;
    localparam int MAX_PLANES_DEF    = 8;
    localparam int MAX_ROWS_DEF      = 4096;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_COMPRESSION_ON = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HAS_MASK_PLANE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_ROW  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_COUNT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT      = 3'd4;

    // Register values after reset.
    localparam logic        RST_COMPRESSION_ON = 1'b1;
    localparam logic        RST_HAS_MASK_PLANE = 1'b0;
    localparam logic [10:0] RST_BYTES_PER_ROW  = 11'd40;
    localparam logic [3:0]  RST_PLANE_COUNT    = 4'd5;
    localparam logic [12:0] RST_ROW_COUNT      = 13'd256;

    // ByteRun1 no-operation header.
    localparam logic [7:0] RUN_NOOP = 8'h80;

    typedef struct packed {
        logic        compression_on;
        logic        has_mask_plane;
        logic [10:0] bytes_per_row;
        logic [3:0]  plane_count;
        logic [12:0] row_count;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  span_value;
        logic [7:0]  span_length;
        logic [9:0]  start_column;
        logic [3:0]  plane_index;
        logic [11:0] row_index;
        logic        keep_span;
        logic        row_overrun;
        logic        image_done;
    } span_t;

endpackage

/* sv/bbd_if.sv */
// ----------------------------------------------------------------------------
// bbd_if
// Valid/ready channels of the body decoder: body bytes in, spans out.
// ----------------------------------------------------------------------------
interface bbd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;

    modport source (output valid, output body_byte, input ready);
    modport sink   (input valid, input body_byte, output ready);
endinterface

interface bbd_span_if;
    logic        valid;
    logic        ready;
    logic [7:0]  span_value;
    logic [7:0]  span_length;
    logic [9:0]  start_column;
    logic [3:0]  plane_index;
    logic [11:0] row_index;
    logic        keep_span;
    logic        row_overrun;
    logic        image_done;

    modport source (output valid, output span_value, output span_length,
                    output start_column, output plane_index, output row_index,
                    output keep_span, output row_overrun, output image_done,
                    input ready);
    modport sink   (input valid, input span_value, input span_length,
                    input start_column, input plane_index, input row_index,
                    input keep_span, input row_overrun, input image_done,
                    output ready);
endinterface

/* sv/bbd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bbd_cfg_regs
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bbd_cfg_regs
    import bbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COMPRESSION_ON: cfg_next.compression_on = cfg_data[0];
                REG_HAS_MASK_PLANE: cfg_next.has_mask_plane = cfg_data[0];
                REG_BYTES_PER_ROW:  cfg_next.bytes_per_row  = cfg_data[10:0];
                REG_PLANE_COUNT:    cfg_next.plane_count    = cfg_data[3:0];
                REG_ROW_COUNT:      cfg_next.row_count      = cfg_data[12:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compression_on <= RST_COMPRESSION_ON;
            cfg_reg.has_mask_plane <= RST_HAS_MASK_PLANE;
            cfg_reg.bytes_per_row  <= RST_BYTES_PER_ROW;
            cfg_reg.plane_count    <= RST_PLANE_COUNT;
            cfg_reg.row_count      <= RST_ROW_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/bbd_decode.sv */
// ----------------------------------------------------------------------------
// bbd_decode
// ByteRun1 run state and picture position; one body byte per transfer.
// ----------------------------------------------------------------------------
module bbd_decode
    import bbd_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
    parameter int MAX_PLANES    = MAX_PLANES_DEF,
    parameter int MAX_ROWS      = MAX_ROWS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic [7:0] body_byte,
    output logic       span_valid,
    output span_t      span
);

    localparam int BPR_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int COL_W  = $clog2(MAX_ROW_BYTES);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_REPEAT  = 2'd2;
    localparam logic [1:0] PH_DROP    = 2'd3;

    logic [1:0]        phase_reg,    phase_next;
    logic [6:0]        literal_reg,  literal_next;
    logic [7:0]        repeat_reg,   repeat_next;
    logic [COL_W-1:0]  column_reg,   column_next;
    logic [3:0]        plane_reg,    plane_next;
    logic [ROWS_W-1:0] row_reg,      row_next;
    logic              finished_reg, finished_next;

    logic [BPR_W-1:0]  bpr;
    logic [3:0]        planes;
    logic [3:0]        per_row;
    logic [ROWS_W-1:0] rows;
    logic [BPR_W-1:0]  column_ext;
    logic [BPR_W-1:0]  room;
    logic [7:0]        want;
    logic              extra_overrun;
    logic              emit;
    logic [7:0]        len;
    logic              overrun;
    logic              row_end;
    logic              done;
    logic [3:0]        plane_inc;
    logic [ROWS_W-1:0] row_inc;

    // Out-of-range settings act as the nearest legal value.
    always_comb
    begin
        if (cfg.bytes_per_row == 11'd0)
            bpr = BPR_W'(1);
        else if (32'(cfg.bytes_per_row) > MAX_ROW_BYTES)
            bpr = BPR_W'(MAX_ROW_BYTES);
        else
            bpr = BPR_W'(cfg.bytes_per_row);

        if (cfg.plane_count == 4'd0)
            planes = 4'd1;
        else if (32'(cfg.plane_count) > MAX_PLANES)
            planes = 4'(MAX_PLANES);
        else
            planes = cfg.plane_count;

        if (cfg.row_count == 13'd0)
            rows = ROWS_W'(1);
        else if (32'(cfg.row_count) > MAX_ROWS)
            rows = ROWS_W'(MAX_ROWS);
        else
            rows = ROWS_W'(cfg.row_count);

        per_row = planes + {3'd0, cfg.has_mask_plane};
    end

    // Run decoding.
    always_comb
    begin
        phase_next    = phase_reg;
        literal_next  = literal_reg;
        repeat_next   = repeat_reg;
        want          = 8'd1;
        extra_overrun = 1'b0;
        emit          = 1'b0;

        if (!finished_reg)
        begin
            if (!cfg.compression_on)
            begin
                emit = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (!body_byte[7])
                        begin
                            literal_next = body_byte[6:0];
                            phase_next   = PH_LITERAL;
                        end
                        else if (body_byte != RUN_NOOP)
                        begin
                            repeat_next = 8'(9'd257 - {1'b0, body_byte});
                            phase_next  = PH_REPEAT;
                        end
                    end
                    PH_LITERAL:
                    begin
                        emit          = 1'b1;
                        extra_overrun = (literal_reg != 7'd0);
                        if (literal_reg == 7'd0)
                        begin
                            phase_next = PH_HEADER;
                        end
                        else
                        begin
                            literal_next = literal_reg - 7'd1;
                            // The rest of a literal run that overflows the row is dropped.
                            if (BPR_W'(column_reg) + BPR_W'(1) >= bpr)
                                phase_next = PH_DROP;
                        end
                    end
                    PH_REPEAT:
                    begin
                        emit       = 1'b1;
                        want       = repeat_reg;
                        phase_next = PH_HEADER;
                    end
                    PH_DROP:
                    begin
                        if (literal_reg == 7'd0)
                            phase_next = PH_HEADER;
                        else
                            literal_next = literal_reg - 7'd1;
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    // Span clipping and position advance.
    always_comb
    begin
        column_ext = BPR_W'(column_reg);
        room       = (column_ext < bpr) ? (bpr - column_ext) : BPR_W'(1);

        if (32'(want) > 32'(room))
        begin
            len     = 8'(room);
            overrun = 1'b1;
        end
        else
        begin
            len     = want;
            overrun = 1'b0;
        end
        row_end = (32'(len) == 32'(room));
        if (row_end && extra_overrun)
            overrun = 1'b1;

        plane_inc     = plane_reg + 4'd1;
        row_inc       = row_reg + ROWS_W'(1);
        column_next   = column_reg;
        plane_next    = plane_reg;
        row_next      = row_reg;
        finished_next = finished_reg;
        done          = 1'b0;

        if (emit)
        begin
            if (row_end)
            begin
                column_next = '0;
                if (plane_inc >= per_row)
                begin
                    plane_next = 4'd0;
                    row_next   = row_inc;
                    if (row_inc >= rows)
                    begin
                        finished_next = 1'b1;
                        done          = 1'b1;
                    end
                end
                else
                begin
                    plane_next = plane_inc;
                end
            end
            else
            begin
                column_next = COL_W'(column_ext + BPR_W'(len));
            end
        end

        span.span_value   = body_byte;
        span.span_length  = len;
        span.start_column = 10'(column_reg);
        span.plane_index  = plane_reg;
        span.row_index    = 12'(row_reg);
        span.keep_span    = (plane_reg < planes);
        span.row_overrun  = overrun;
        span.image_done   = done;
        span_valid        = step && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            literal_reg  <= 7'd0;
            repeat_reg   <= 8'd0;
            column_reg   <= '0;
            plane_reg    <= 4'd0;
            row_reg      <= '0;
            finished_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            literal_reg  <= literal_next;
            repeat_reg   <= repeat_next;
            column_reg   <= column_next;
            plane_reg    <= plane_next;
            row_reg      <= row_next;
            finished_reg <= finished_next;
        end
    end

endmodule

/* sv/bbd_span_reg.sv */
// ----------------------------------------------------------------------------
// bbd_span_reg
// Result register between the decoder and the span channel.
// ----------------------------------------------------------------------------
module bbd_span_reg
    import bbd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  span_t span_in,
    output logic  can_load,
    output logic  valid,
    input  logic  ready,
    output span_t span_out
);

    logic  valid_reg, valid_next;
    span_t span_reg;

    // A new span may enter while the held one leaves in the same cycle.
    assign can_load = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            span_reg <= span_in;
    end

    assign valid    = valid_reg;
    assign span_out = span_reg;

endmodule

/* sv/ilbm_byterun1_body_decoder.sv */
// ----------------------------------------------------------------------------
// ilbm_byterun1_body_decoder
// ByteRun1 / raw BODY decoder for interleaved bitplane pictures.
// ----------------------------------------------------------------------------
// Takes one body byte per transfer and returns at most one span per byte:
// value, length, column, plane and row, with a discard mark on mask-plane
// spans and an overrun flag on runs clipped at the row end. The run and
// position counters update in the cycle the byte is transferred, and the
// span lands in a single result register, so a byte is accepted in every
// cycle unless a span in that register is still waiting to be taken. After
// the last row completes, further bytes are taken and ignored until reset.
// The user must write configuration only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module ilbm_byterun1_body_decoder
    import bbd_pkg::*;
#(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
    parameter int MAX_PLANES    = MAX_PLANES_DEF,
    parameter int MAX_ROWS      = MAX_ROWS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    bbd_byte_if.sink               body_in,
    bbd_span_if.source             span_out
);

    cfg_t  cfg;
    logic  step;
    logic  span_valid;
    span_t span;
    logic  can_load;
    span_t span_q;

    bbd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign body_in.ready = can_load;
    assign step          = body_in.valid && can_load;

    bbd_decode
    #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_PLANES    (MAX_PLANES),
        .MAX_ROWS      (MAX_ROWS)
    )
    u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step       (step),
        .body_byte  (body_in.body_byte),
        .span_valid (span_valid),
        .span       (span)
    );

    bbd_span_reg u_span_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (span_valid),
        .span_in  (span),
        .can_load (can_load),
        .valid    (span_out.valid),
        .ready    (span_out.ready),
        .span_out (span_q)
    );

    assign span_out.span_value   = span_q.span_value;
    assign span_out.span_length  = span_q.span_length;
    assign span_out.start_column = span_q.start_column;
    assign span_out.plane_index  = span_q.plane_index;
    assign span_out.row_index    = span_q.row_index;
    assign span_out.keep_span    = span_q.keep_span;
    assign span_out.row_overrun  = span_q.row_overrun;
    assign span_out.image_done   = span_q.image_done;

endmodule
